### rtl/lzwd_pkg.sv
// ---------------------------------------------------------------------------
// lzwd_pkg
// Shared types for the LZSS window decompressor: controller states and the
// command and status groups that join the controller to the datapath.
// ---------------------------------------------------------------------------
package lzwd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LITERAL,
    ST_MATCH
  } lzwd_state_t;

  // controller to datapath
  typedef struct packed {
    logic start_literal;  // latch literal byte of the accepted token
    logic start_match;    // latch copy start and length, issue first read
    logic end_stream;     // return write position to its start value
    logic advance;        // emit one word and write it to the window
    logic src_literal;    // emitted word comes from the literal register
  } lzwd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tok_literal;    // offered token is a literal
    logic tok_end;        // offered token is an end-of-stream mark
    logic out_free;       // output register can take a word this cycle
    logic last;           // word being produced is the last of its token
  } lzwd_status_t;

endpackage

### rtl/lzwd_token_if.sv
// ---------------------------------------------------------------------------
// lzwd_token_if
// Token channel: one unpacked LZSS token per word, valid/ready handshake.
// ---------------------------------------------------------------------------
interface lzwd_token_if;
  logic        valid;
  logic        ready;
  logic        is_literal;
  logic [7:0]  literal_byte;
  logic [11:0] match_position;
  logic [3:0]  length_code;

  modport source (
    output valid, is_literal, literal_byte, match_position, length_code,
    input  ready
  );
  modport sink (
    input  valid, is_literal, literal_byte, match_position, length_code,
    output ready
  );
endinterface

### rtl/lzwd_byte_if.sv
// ---------------------------------------------------------------------------
// lzwd_byte_if
// Output channel: one decompressed byte per word, valid/ready handshake.
// ---------------------------------------------------------------------------
interface lzwd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (
    output valid, out_byte, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last_of_run,
    output ready
  );
endinterface

### rtl/lzwd_window_decompressor.sv
// ---------------------------------------------------------------------------
// lzss_window_decompressor
// Top level of the LZSS window decompressor: token in, byte stream out.
// ---------------------------------------------------------------------------
// Feed one unpacked LZSS token per word on the token channel and take the
// decompressed bytes from the result channel, one byte per word, with
// last_of_run high on the final byte of each token. A literal token yields
// its byte; a match token yields length_code + BREAK_EVEN + 1 bytes copied
// from the history window starting at match_position (wrapping), where
// BREAK_EVEN = (1 + INDEX_BITS + LENGTH_BITS) / 9; a match with position 0
// ends the stream, yields nothing and returns the write position to 1.
// Timing: a token is taken only while the block is idle. A literal or match
// keeps it busy until the last byte has entered the output register, and a
// result-side stall holds it there; an end token leaves it idle. The window's
// single registered read port supplies one copy byte per cycle while the
// result side does not stall, after a first read issued with the match.
// Overlapping copies are handled by forwarding the byte written in the same
// cycle. The window holds no reset value and needs no clearing pass; a copy
// must only reach entries already written since reset.
// ---------------------------------------------------------------------------
module lzss_window_decompressor
  import lzwd_pkg::*;
#(
  parameter int INDEX_BITS  = 12,
  parameter int LENGTH_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  lzwd_token_if.sink  token,
  lzwd_byte_if.source result
);

  lzwd_cmd_t    cmd;
  lzwd_status_t status;

  // sequencer: token acceptance and one step per output word
  lzwd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (token.valid),
    .in_ready (token.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // window, pointers, run counter and output register
  lzwd_datapath #(
    .INDEX_BITS  (INDEX_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .tok_is_literal     (token.is_literal),
    .tok_literal_byte   (token.literal_byte),
    .tok_match_position (token.match_position),
    .tok_length_code    (token.length_code),
    .cmd                (cmd),
    .status             (status),
    .dout               (result)
  );

endmodule

### rtl/lzwd_controller.sv
// ---------------------------------------------------------------------------
// lzwd_controller
// Token sequencer: accepts a token when idle, then, while the output register
// is free, steps the datapath one word per cycle until its run is done.
// ---------------------------------------------------------------------------
module lzwd_controller
  import lzwd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  lzwd_status_t status,
  output lzwd_cmd_t    cmd
);

  lzwd_state_t state, state_next;
  logic        accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (status.tok_literal) begin
            state_next = ST_LITERAL;
          end else if (!status.tok_end) begin
            state_next = ST_MATCH;
          end
        end
      end
      ST_LITERAL: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_MATCH: begin
        if (status.out_free && status.last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.start_literal = accept && status.tok_literal;
        cmd.start_match   = accept && !status.tok_literal && !status.tok_end;
        cmd.end_stream    = accept && !status.tok_literal && status.tok_end;
      end
      ST_LITERAL: begin
        cmd.src_literal = 1'b1;
        cmd.advance     = status.out_free;
      end
      ST_MATCH: begin
        cmd.advance = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/lzwd_datapath.sv
// ---------------------------------------------------------------------------
// lzwd_datapath
// History window, write and read pointers, run counter and the output
// register that drives the byte channel.
// ---------------------------------------------------------------------------
module lzwd_datapath
  import lzwd_pkg::*;
#(
  parameter int INDEX_BITS  = 12,
  parameter int LENGTH_BITS = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         tok_is_literal,
  input  logic [7:0]   tok_literal_byte,
  input  logic [11:0]  tok_match_position,
  input  logic [3:0]   tok_length_code,
  input  lzwd_cmd_t    cmd,
  output lzwd_status_t status,
  lzwd_byte_if.source  dout
);

  localparam int WIN_SIZE   = 1 << INDEX_BITS;
  localparam int POS_W      = (INDEX_BITS < 12) ? INDEX_BITS : 12;
  localparam int CODE_W     = (LENGTH_BITS < 4) ? LENGTH_BITS : 4;
  localparam int BREAK_EVEN = (1 + INDEX_BITS + LENGTH_BITS) / 9;
  localparam int LEN_MAX    = (1 << CODE_W) - 1 + BREAK_EVEN + 1;
  localparam int CNT_W      = $clog2(LEN_MAX + 1);

  logic [7:0]            window [WIN_SIZE];

  logic [INDEX_BITS-1:0] wp;
  logic [INDEX_BITS-1:0] rd_ptr;
  logic [CNT_W-1:0]      remaining;
  logic [7:0]            lit_q;
  logic [7:0]            mem_q;
  logic                  bypass;
  logic [7:0]            bypass_data;
  logic [7:0]            obyte;
  logic                  olast;
  logic                  ovalid;

  logic [INDEX_BITS-1:0] start_pos;
  logic [CNT_W-1:0]      run_len;
  logic                  rd_en;
  logic [INDEX_BITS-1:0] rd_addr;
  logic [7:0]            cur_byte;
  logic                  cur_last;

  assign start_pos = INDEX_BITS'(tok_match_position[POS_W-1:0]);
  assign run_len   = CNT_W'(tok_length_code[CODE_W-1:0]) + CNT_W'(BREAK_EVEN) + CNT_W'(1);

  assign cur_byte = cmd.src_literal ? lit_q : (bypass ? bypass_data : mem_q);
  assign cur_last = cmd.src_literal || (remaining == CNT_W'(1));

  // first read at the copy start, later reads one step ahead of the output
  assign rd_en   = cmd.start_match || (cmd.advance && !cmd.src_literal);
  assign rd_addr = cmd.start_match ? start_pos : rd_ptr;

  assign status.tok_literal = tok_is_literal;
  assign status.tok_end     = (start_pos == '0);
  assign status.out_free    = !ovalid || dout.ready;
  assign status.last        = cur_last;

  assign dout.valid       = ovalid;
  assign dout.out_byte    = obyte;
  assign dout.last_of_run = olast;

  // window: one write and one registered read per cycle, read returns old data
  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      window[wp] <= cur_byte;
    end
    if (rd_en) begin
      mem_q <= window[rd_addr];
    end
  end

  // forward the word being written when the next read hits the same entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      bypass      <= cmd.advance && (rd_addr == wp);
      bypass_data <= cur_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= INDEX_BITS'(1);
    end else if (cmd.end_stream) begin
      wp <= INDEX_BITS'(1);
    end else if (cmd.advance) begin
      wp <= wp + INDEX_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_literal) begin
      lit_q <= tok_literal_byte;
    end
    if (cmd.start_match) begin
      rd_ptr    <= start_pos + INDEX_BITS'(1);
      remaining <= run_len;
    end else if (cmd.advance && !cmd.src_literal) begin
      rd_ptr    <= rd_ptr + INDEX_BITS'(1);
      remaining <= remaining - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (cmd.advance) begin
      ovalid <= 1'b1;
    end else if (dout.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      obyte <= cur_byte;
      olast <= cur_last;
    end
  end

endmodule

### tb/sv/tb_lzss_window_decompressor.sv
// ---------------------------------------------------------------------------
// tb_lzss_window_decompressor
// Self-checking bench for the LZSS window decompressor. A scoreboard keeps
// its own copy of the history window and write position, expands every
// accepted token into the bytes it should yield, and checks each word
// leaving the block in order. A short directed pass is followed by random
// tokens that stay mostly well-formed matches until the window has wrapped.
// ---------------------------------------------------------------------------
module tb_lzss_window_decompressor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int INDEX_W     = 12;
  localparam int LEN_W       = 4;
  localparam int WIN_DEPTH   = 1 << INDEX_W;
  // each copy yields this many bytes, plus one, on top of its length code
  localparam int RUN_EXTRA   = (1 + INDEX_W + LEN_W) / 9;
  localparam int MAX_RUN     = (1 << LEN_W) - 1 + RUN_EXTRA + 1;
  localparam int MAX_TOKENS  = 320;
  localparam int AFTER_WRAP  = 20;
  localparam int MAX_REPORTS = 40;

  typedef logic [INDEX_W-1:0] win_addr_t;
  typedef logic [LEN_W-1:0]   len_code_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } out_word_t;

  // Tracks the window contents and the bytes still owed by the block.
  class byte_scoreboard;
    logic [7:0] history [WIN_DEPTH];
    bit         written [WIN_DEPTH];
    win_addr_t  wr_pos;
    bit         wrapped;
    out_word_t  pending_bytes[$];
    int         errors;

    function new();
      wr_pos  = 1;
      wrapped = 0;
      errors  = 0;
    endfunction

    function void push_byte(logic [7:0] b, logic last);
      pending_bytes.push_back('{value: b, last: last});
      history[wr_pos] = b;
      written[wr_pos] = 1'b1;
      if (wr_pos == win_addr_t'(WIN_DEPTH - 1)) wrapped = 1'b1;
      wr_pos = wr_pos + 1'b1;
    endfunction

    // Expand one accepted token into the bytes it yields.
    function void note_token(logic lit, logic [7:0] lbyte, win_addr_t pos,
                             len_code_t code);
      int        count;
      win_addr_t src;
      if (lit) begin
        push_byte(lbyte, 1'b1);
      end else if (pos == '0) begin
        wr_pos = 1;
      end else begin
        count = int'(code) + RUN_EXTRA + 1;
        src   = pos;
        // read after each write so an overlapping copy repeats itself
        for (int i = 0; i < count; i++) begin
          push_byte(history[src], i == count - 1);
          src = src + 1'b1;
        end
      end
    endfunction

    // True when every byte the copy reads is written by the time it is read.
    function bit copy_safe(win_addr_t pos, int count);
      win_addr_t addr;
      for (int i = 0; i < count; i++) begin
        addr = pos + win_addr_t'(i);
        if (!written[addr] && int'(win_addr_t'(addr - wr_pos)) >= i) return 1'b0;
      end
      return 1'b1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task check_byte(logic [7:0] b, logic last);
      out_word_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected word %02h last %0b", b, last));
        return;
      end
      want = pending_bytes.pop_front();
      if (b !== want.value)
        report($sformatf("out_byte %02h, want %02h", b, want.value));
      if (last !== want.last)
        report($sformatf("last_of_run %0b, want %0b (byte %02h)", last, want.last, b));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   calm = 1'b0;

  byte_scoreboard sb;

  lzwd_token_if token_ch ();
  lzwd_byte_if  byte_ch ();

  lzss_window_decompressor #(
    .INDEX_BITS  (INDEX_W),
    .LENGTH_BITS (LEN_W)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .token  (token_ch),
    .result (byte_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random idle length: mostly none or short, now and then long. While calm
  // is set neither side idles at all.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Toggle between idling and back-to-back stretches.
  initial begin
    forever begin
      repeat ($urandom_range(40, 400)) @(posedge clk);
      calm <= ~calm;
    end
  end

  // Offer one token, hold it until the block takes it, then record it.
  // Drop valid only when a gap follows, so back-to-back tokens keep it high.
  task automatic send_token(logic lit, logic [7:0] lbyte, win_addr_t pos,
                            len_code_t code);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      token_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    token_ch.valid          <= 1'b1;
    token_ch.is_literal     <= lit;
    token_ch.literal_byte   <= lbyte;
    token_ch.match_position <= pos;
    token_ch.length_code    <= code;
    do @(posedge clk); while (!token_ch.ready);
    sb.note_token(lit, lbyte, pos, code);
  endtask

  // Result side: check each accepted word, then stall at random.
  initial begin
    int stall;
    stall = 0;
    byte_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && byte_ch.valid && byte_ch.ready)
        sb.check_byte(byte_ch.out_byte, byte_ch.last_of_run);
      if (stall > 0) begin
        byte_ch.ready <= 1'b0;
        stall--;
      end else begin
        byte_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int        n;
    int        wrap_at;
    int        r;
    bit        found;
    win_addr_t pos;
    len_code_t code;

    sb = new();
    rst                     <= 1'b1;
    token_ch.valid          <= 1'b0;
    token_ch.is_literal     <= 1'b0;
    token_ch.literal_byte   <= '0;
    token_ch.match_position <= '0;
    token_ch.length_code    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed pass. Seed the window with extreme literals, carrying
    // junk in the ignored fields.
    send_token(1'b1, 8'h00, 12'hFFF, 4'hF);
    send_token(1'b1, 8'hFF, 12'h000, 4'h0);
    send_token(1'b1, 8'hA5, 12'h555, 4'h5);
    send_token(1'b1, 8'h5A, 12'hAAA, 4'hA);
    // shortest copy, then the longest one running into its own output
    send_token(1'b0, 8'hFF, 12'd1, 4'h0);
    send_token(1'b0, 8'h00, 12'd1, 4'hF);
    // distance of one: a run of the same byte
    send_token(1'b0, 8'h3C, 12'd23, 4'hF);
    // end of stream: write position restarts, window contents stay
    send_token(1'b0, 8'hFF, 12'd0, 4'hF);
    send_token(1'b0, 8'hFF, 12'd30, 4'h3);
    // a literal with a zero position is still a literal
    send_token(1'b1, 8'h80, 12'd0, 4'h0);
    send_token(1'b0, 8'h00, 12'd2, 4'h4);
    // back-to-back end marks
    send_token(1'b0, 8'h00, 12'd0, 4'h0);
    send_token(1'b0, 8'h00, 12'd0, 4'h0);
    send_token(1'b1, 8'h01, 12'h800, 4'h8);
    send_token(1'b0, 8'h00, 12'd1, 4'h7);

    // Random pass. Send the longest copies, or a literal where no safe copy is
    // found, until the write position has wrapped the whole window, then mix
    // lengths, literals and end marks for a short while.
    n       = 0;
    wrap_at = 0;
    while ((!sb.wrapped || n < wrap_at + AFTER_WRAP) && n < MAX_TOKENS) begin
      if (sb.wrapped && wrap_at == 0) wrap_at = n;
      r     = $urandom_range(0, 99);
      code  = len_code_t'((1 << LEN_W) - 1);
      if (sb.wrapped && $urandom_range(0, 3) == 0)
        code = len_code_t'($urandom_range(0, (1 << LEN_W) - 1));
      found = 1'b0;
      if (sb.wrapped && r < 5) begin
        send_token(1'b0, 8'($urandom), '0, len_code_t'($urandom));
      end else begin
        if (r >= 15 || !sb.wrapped) begin
          // try near the write position, across the written span, and at the top
          for (int t = 0; t < 16 && !found; t++) begin
            case ($urandom_range(0, 2))
              0: pos = sb.wr_pos - win_addr_t'($urandom_range(1, 8));
              1: pos = sb.wrapped ? win_addr_t'($urandom_range(1, WIN_DEPTH - 1))
                                  : win_addr_t'($urandom_range(1, (sb.wr_pos > 1) ?
                                                                  sb.wr_pos - 1 : 1));
              default: pos = win_addr_t'(WIN_DEPTH - 1 - $urandom_range(0, 20));
            endcase
            found = (pos != '0) && sb.copy_safe(pos, int'(code) + RUN_EXTRA + 1);
          end
        end
        if (found)
          send_token(1'b0, 8'($urandom), pos, code);
        else
          send_token(1'b1, 8'($urandom), win_addr_t'($urandom), len_code_t'($urandom));
      end
      n++;
    end

    // Drain: wait for every owed byte, then keep watching for stray words.
    token_ch.valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (2 * (MAX_RUN + 2)) @(posedge clk);

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
